### src/stbcs_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and the box overlap test for the slot table collision scanner.
package stbcs_pkg;

    localparam int SLOT_COUNT = 1024;
    localparam int COORD_BITS = 16;
    localparam int IDX_W      = 10;
    localparam int CELL_COUNT = 8;
    localparam int CELL_BITS  = $clog2(CELL_COUNT);
    localparam int BANK_BITS  = $clog2((SLOT_COUNT + CELL_COUNT - 1) / CELL_COUNT);
    localparam int BANK_DEPTH = 1 << BANK_BITS;
    localparam int SLOT_BITS  = CELL_BITS + BANK_BITS;
    localparam int DIM_BITS   = COORD_BITS - 1;
    localparam int SUM_BITS   = COORD_BITS + 1;
    localparam int CMP_W      = (SLOT_BITS > IDX_W) ? SLOT_BITS : IDX_W;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_ALLOC = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;
    localparam logic [1:0] OP_QUERY = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_MISS      = 2'd1;
    localparam logic [1:0] ST_NO_SOURCE = 2'd2;

    typedef struct packed {
        logic                  collidable;
        logic [COORD_BITS-1:0] left;
        logic [COORD_BITS-1:0] top;
        logic [DIM_BITS-1:0]   width;
        logic [DIM_BITS-1:0]   height;
        logic                  has_owner;
        logic [IDX_W-1:0]      owner;
    } entry_t;

    typedef struct packed {
        logic                 valid;
        logic [SLOT_BITS-1:0] num;
    } chain_t;

    typedef struct packed {
        logic                 wr_en;
        logic                 wr_all;
        logic [CELL_BITS-1:0] wr_cell;
        logic [BANK_BITS-1:0] wr_addr;
        logic                 wr_used_en;
        logic                 wr_used;
        logic                 wr_data_en;
        entry_t               wr_data;
        logic [BANK_BITS-1:0] rd_addr;
        logic                 probe_valid;
        logic                 scan_clear;
        logic                 alloc_mode;
        entry_t               src;
        logic [IDX_W-1:0]     src_idx;
    } cell_cmd_t;

    typedef struct packed {
        logic   used;
        entry_t data;
    } cell_rd_t;

    // Edge-inclusive overlap test with sums one bit wider than the coordinates.
    function automatic logic boxes_touch(entry_t a, entry_t b);
        logic signed [SUM_BITS-1:0] al;
        logic signed [SUM_BITS-1:0] at;
        logic signed [SUM_BITS-1:0] bl;
        logic signed [SUM_BITS-1:0] bt;
        logic signed [SUM_BITS-1:0] ar;
        logic signed [SUM_BITS-1:0] ab;
        logic signed [SUM_BITS-1:0] br;
        logic signed [SUM_BITS-1:0] bb;
        al = $signed({a.left[COORD_BITS-1], a.left});
        at = $signed({a.top[COORD_BITS-1], a.top});
        bl = $signed({b.left[COORD_BITS-1], b.left});
        bt = $signed({b.top[COORD_BITS-1], b.top});
        ar = al + $signed({2'b00, a.width});
        ab = at + $signed({2'b00, a.height});
        br = bl + $signed({2'b00, b.width});
        bb = bt + $signed({2'b00, b.height});
        return (ar >= bl) && (al <= br) && (ab >= bt) && (at <= bb);
    endfunction

endpackage

### src/stbcs_cell.sv
`timescale 1ns / 1ps
// One scan cell: a bank of slots, its candidate test and one stage of the result chain.
module stbcs_cell
    import stbcs_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [CELL_BITS-1:0] cell_id,
    input  cell_cmd_t            cmd,
    input  chain_t               chain_in,
    output cell_rd_t             rd_out,
    output chain_t               chain_out
);

    logic   used_mem [BANK_DEPTH];
    entry_t data_mem [BANK_DEPTH];

    logic                 used_rd_reg;
    entry_t               data_rd_reg;
    logic [BANK_BITS-1:0] probe_k_reg;
    logic                 probe_valid_reg;
    chain_t               hit_reg;
    chain_t               hit_next;
    chain_t               chain_reg;
    chain_t               chain_next;

    logic                 wr_sel;
    logic [SLOT_BITS-1:0] slot_num;
    logic                 in_range;
    logic                 skip;
    logic                 candidate;

    assign wr_sel = cmd.wr_en && (cmd.wr_all || (cmd.wr_cell == cell_id));

    always_ff @(posedge aclk) begin
        if (wr_sel && cmd.wr_used_en) begin
            used_mem[cmd.wr_addr] <= cmd.wr_used;
        end
        if (wr_sel && cmd.wr_data_en) begin
            data_mem[cmd.wr_addr] <= cmd.wr_data;
        end
        used_rd_reg <= used_mem[cmd.rd_addr];
        data_rd_reg <= data_mem[cmd.rd_addr];
        probe_k_reg <= cmd.rd_addr;
    end

    assign slot_num = {cell_id, probe_k_reg};
    assign in_range = 32'(slot_num) < SLOT_COUNT;
    assign skip     = (CMP_W'(slot_num) == CMP_W'(cmd.src_idx)) ||
                      (cmd.src.has_owner && (CMP_W'(slot_num) == CMP_W'(cmd.src.owner)));

    always_comb begin
        if (cmd.alloc_mode) begin
            candidate = probe_valid_reg && in_range && !used_rd_reg;
        end else begin
            candidate = probe_valid_reg && in_range && used_rd_reg && !skip &&
                        data_rd_reg.collidable && boxes_touch(cmd.src, data_rd_reg);
        end
    end

    always_comb begin
        hit_next = hit_reg;
        if (cmd.scan_clear) begin
            hit_next = '0;
        end else if (candidate && !hit_reg.valid) begin
            hit_next.valid = 1'b1;
            hit_next.num   = slot_num;
        end
        chain_next = hit_reg.valid ? hit_reg : chain_in;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            probe_valid_reg <= 1'b0;
            hit_reg         <= '0;
            chain_reg       <= '0;
        end else begin
            probe_valid_reg <= cmd.probe_valid;
            hit_reg         <= hit_next;
            chain_reg       <= chain_next;
        end
    end

    assign rd_out.used = used_rd_reg;
    assign rd_out.data = data_rd_reg;
    assign chain_out   = chain_reg;

endmodule

### src/slot_table_box_collision_scan.sv
`timescale 1ns / 1ps
// Slot table with first-hit box collision scan: control sequencer and chain of scan cells.
// Write and free pass through the execute and done states; allocate and query scan the
// 128-entry bank of every cell, one slot per cycle in each cell, then drain the 8-stage
// result chain (query reads its source slot first). One item is in flight at a time; a new
// item is taken while a result waits. After reset a clearing pass empties every bank
// before the first input transfer is taken.
module slot_table_box_collision_scan
    import stbcs_pkg::*;
(
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [1:0]                   s_operation,
    input  logic [IDX_W-1:0]             s_slot_index,
    input  logic                         s_is_collidable,
    input  logic signed [COORD_BITS-1:0] s_box_left,
    input  logic signed [COORD_BITS-1:0] s_box_top,
    input  logic [DIM_BITS-1:0]          s_box_width,
    input  logic [DIM_BITS-1:0]          s_box_height,
    input  logic                         s_has_owner,
    input  logic [IDX_W-1:0]             s_owner_slot,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [1:0]                   m_status,
    output logic [IDX_W-1:0]             m_found_slot
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_SRC   = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_DRAIN = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    localparam int                   DRAIN_BITS = $clog2(CELL_COUNT + 2);
    localparam logic [DRAIN_BITS-1:0] DRAIN_LAST = DRAIN_BITS'(CELL_COUNT + 1);
    localparam logic [BANK_BITS-1:0]  K_LAST     = BANK_BITS'(BANK_DEPTH - 1);

    logic [2:0]            state_reg;
    logic [2:0]            state_next;
    logic [BANK_BITS-1:0]  k_reg;
    logic [BANK_BITS-1:0]  k_next;
    logic [DRAIN_BITS-1:0] drain_reg;
    logic [DRAIN_BITS-1:0] drain_next;
    logic [1:0]            op_reg;
    logic [IDX_W-1:0]      idx_reg;
    entry_t                in_entry_reg;
    entry_t                src_reg;
    entry_t                src_next;
    logic [1:0]            res_status_reg;
    logic [1:0]            res_status_next;
    logic [IDX_W-1:0]      res_found_reg;
    logic [IDX_W-1:0]      res_found_next;
    logic                  m_valid_reg;
    logic [1:0]            m_status_reg;
    logic [IDX_W-1:0]      m_found_reg;

    cell_cmd_t             cmd;
    cell_rd_t              rd_arr    [CELL_COUNT];
    chain_t                chain_arr [CELL_COUNT+1];
    cell_rd_t              src_rd;
    logic [CELL_BITS-1:0]  idx_cell;
    logic [BANK_BITS-1:0]  idx_addr;
    logic                  idx_in_range;
    logic                  out_free;

    assign idx_cell     = idx_reg[BANK_BITS +: CELL_BITS];
    assign idx_addr     = idx_reg[BANK_BITS-1:0];
    assign idx_in_range = 32'(idx_reg) < SLOT_COUNT;
    assign src_rd       = rd_arr[idx_cell];
    assign out_free     = !m_valid_reg || m_ready;
    assign chain_arr[CELL_COUNT] = '0;

    genvar g;
    generate
        for (g = 0; g < CELL_COUNT; g++) begin : g_cell
            stbcs_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .cell_id   (CELL_BITS'(g)),
                .cmd       (cmd),
                .chain_in  (chain_arr[g+1]),
                .rd_out    (rd_arr[g]),
                .chain_out (chain_arr[g])
            );
        end
    endgenerate

    always_comb begin
        cmd             = '0;
        cmd.rd_addr     = idx_addr;
        cmd.src         = src_reg;
        cmd.src_idx     = idx_reg;
        cmd.alloc_mode  = (op_reg == OP_ALLOC);
        state_next      = state_reg;
        k_next          = k_reg;
        drain_next      = drain_reg;
        src_next        = src_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        case (state_reg)
            S_CLEAR: begin
                cmd.wr_en      = 1'b1;
                cmd.wr_all     = 1'b1;
                cmd.wr_addr    = k_reg;
                cmd.wr_used_en = 1'b1;
                cmd.wr_data_en = 1'b1;
                k_next         = k_reg + 1'b1;
                if (k_reg == K_LAST) begin
                    k_next     = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                res_status_next = ST_OK;
                res_found_next  = '0;
                case (op_reg)
                    OP_WRITE: begin
                        cmd.wr_en      = idx_in_range;
                        cmd.wr_cell    = idx_cell;
                        cmd.wr_addr    = idx_addr;
                        cmd.wr_data_en = 1'b1;
                        cmd.wr_data    = in_entry_reg;
                        state_next     = S_DONE;
                    end
                    OP_FREE: begin
                        cmd.wr_en      = idx_in_range;
                        cmd.wr_cell    = idx_cell;
                        cmd.wr_addr    = idx_addr;
                        cmd.wr_used_en = 1'b1;
                        cmd.wr_data_en = 1'b1;
                        state_next     = S_DONE;
                    end
                    OP_ALLOC: begin
                        cmd.scan_clear = 1'b1;
                        k_next         = '0;
                        state_next     = S_SCAN;
                    end
                    default: begin
                        if (!idx_in_range) begin
                            res_status_next = ST_NO_SOURCE;
                            state_next      = S_DONE;
                        end else begin
                            state_next = S_SRC;
                        end
                    end
                endcase
            end
            S_SRC: begin
                if (!src_rd.used) begin
                    res_status_next = ST_NO_SOURCE;
                    state_next      = S_DONE;
                end else begin
                    src_next       = src_rd.data;
                    cmd.scan_clear = 1'b1;
                    k_next         = '0;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN: begin
                cmd.probe_valid = 1'b1;
                cmd.rd_addr     = k_reg;
                k_next          = k_reg + 1'b1;
                if (k_reg == K_LAST) begin
                    k_next     = '0;
                    drain_next = '0;
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == DRAIN_LAST) begin
                    if (chain_arr[0].valid) begin
                        res_status_next = ST_OK;
                        res_found_next  = IDX_W'(chain_arr[0].num);
                        if (op_reg == OP_ALLOC) begin
                            cmd.wr_en      = 1'b1;
                            cmd.wr_cell    = chain_arr[0].num[SLOT_BITS-1:BANK_BITS];
                            cmd.wr_addr    = chain_arr[0].num[BANK_BITS-1:0];
                            cmd.wr_used_en = 1'b1;
                            cmd.wr_used    = 1'b1;
                        end
                    end else begin
                        res_status_next = ST_MISS;
                        res_found_next  = '0;
                    end
                    state_next = S_DONE;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            k_reg       <= '0;
            drain_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            k_reg     <= k_next;
            drain_reg <= drain_next;
            if (state_reg == S_DONE && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        src_reg        <= src_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        if (state_reg == S_IDLE && s_valid) begin
            op_reg                  <= s_operation;
            idx_reg                 <= s_slot_index;
            in_entry_reg.collidable <= s_is_collidable;
            in_entry_reg.left       <= s_box_left;
            in_entry_reg.top        <= s_box_top;
            in_entry_reg.width      <= s_box_width;
            in_entry_reg.height     <= s_box_height;
            in_entry_reg.has_owner  <= s_has_owner;
            in_entry_reg.owner      <= s_has_owner ? s_owner_slot : '0;
        end
        if (state_reg == S_DONE && out_free) begin
            m_status_reg <= res_status_reg;
            m_found_reg  <= res_found_reg;
        end
    end

    assign s_ready      = (state_reg == S_IDLE);
    assign m_valid      = m_valid_reg;
    assign m_status     = m_status_reg;
    assign m_found_slot = m_found_reg;

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == ST_OK || m_status == ST_MISS || m_status == ST_NO_SOURCE))
        else $error("Result status outside the defined codes.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != ST_OK) |-> (m_found_slot == '0))
        else $error("Found slot is nonzero on a miss.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DRAIN && drain_reg == DRAIN_LAST && op_reg == OP_ALLOC &&
         chain_arr[0].valid) |-> (cmd.wr_en && cmd.wr_used_en && cmd.wr_used))
        else $error("Allocation hit did not mark its slot as used.");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_SCAN) |=> (state_reg == S_SCAN || state_reg == S_DRAIN))
        else $error("Scan left without draining the result chain.");

endmodule

### sim/tb_slot_table_box_collision_scan.sv
`timescale 1ns / 1ps
// Self-checking testbench for the slot table box collision scanner.
module tb_slot_table_box_collision_scan;
    import stbcs_pkg::*;

    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 200;
    localparam int RANDOM_ITEMS  = 536;

    typedef struct {
        logic [1:0]                   op;
        logic [IDX_W-1:0]             idx;
        logic                         coll;
        logic signed [COORD_BITS-1:0] left;
        logic signed [COORD_BITS-1:0] top;
        logic [DIM_BITS-1:0]          wid;
        logic [DIM_BITS-1:0]          hgt;
        logic                         hown;
        logic [IDX_W-1:0]             own;
        bit                           drain;
    } slot_cmd_t;

    typedef struct {
        logic [1:0]       status;
        logic [IDX_W-1:0] found;
    } scan_reply_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic [1:0]                   s_operation = OP_WRITE;
    logic [IDX_W-1:0]             s_slot_index = '0;
    logic                         s_is_collidable = 1'b0;
    logic signed [COORD_BITS-1:0] s_box_left = '0;
    logic signed [COORD_BITS-1:0] s_box_top = '0;
    logic [DIM_BITS-1:0]          s_box_width = '0;
    logic [DIM_BITS-1:0]          s_box_height = '0;
    logic                         s_has_owner = 1'b0;
    logic [IDX_W-1:0]             s_owner_slot = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [1:0]                   m_status;
    logic [IDX_W-1:0]             m_found_slot;

    slot_table_box_collision_scan u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_operation     (s_operation),
        .s_slot_index    (s_slot_index),
        .s_is_collidable (s_is_collidable),
        .s_box_left      (s_box_left),
        .s_box_top       (s_box_top),
        .s_box_width     (s_box_width),
        .s_box_height    (s_box_height),
        .s_has_owner     (s_has_owner),
        .s_owner_slot    (s_owner_slot),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_status        (m_status),
        .m_found_slot    (m_found_slot)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    slot_cmd_t   cmd_backlog[$];
    scan_reply_t reply_queue[$];
    slot_cmd_t   cur_cmd;
    bit          s_taken = 1'b0;
    int          gap_left = 0;
    int          stall_left = 0;
    int          idle_cycles = 0;
    int          n_fail = 0;
    logic [31:0] cycle_count = '0;
    wire         calm = (cycle_count[13:12] == 2'd1);

    // Shadow of the slot table, updated as each transfer is accepted.
    bit     tbl_used [SLOT_COUNT];
    bit     tbl_coll [SLOT_COUNT];
    longint tbl_left [SLOT_COUNT];
    longint tbl_top  [SLOT_COUNT];
    longint tbl_wid  [SLOT_COUNT];
    longint tbl_hgt  [SLOT_COUNT];
    bit     tbl_hown [SLOT_COUNT];
    int     tbl_own  [SLOT_COUNT];

    int n_alloc = 0, n_full = 0, n_write = 0, n_free = 0;
    int n_query = 0, n_hit = 0, n_miss = 0, n_nosrc = 0;

    // Occupancy as seen while the stimulus is built, used to aim indexes at live slots.
    bit gen_used [SLOT_COUNT];
    int gen_live[$];

    function automatic bit boxes_meet(int a, int b);
        return (tbl_left[a] + tbl_wid[a] >= tbl_left[b]) &&
               (tbl_left[a] <= tbl_left[b] + tbl_wid[b]) &&
               (tbl_top[a] + tbl_hgt[a] >= tbl_top[b]) &&
               (tbl_top[a] <= tbl_top[b] + tbl_hgt[b]);
    endfunction

    function automatic scan_reply_t table_apply(slot_cmd_t c);
        scan_reply_t r;
        int          src;
        r.status = ST_OK;
        r.found  = '0;
        src      = int'(c.idx);
        case (c.op)
            OP_WRITE: begin
                n_write++;
                tbl_coll[src] = c.coll;
                tbl_left[src] = longint'(c.left);
                tbl_top[src]  = longint'(c.top);
                tbl_wid[src]  = longint'(c.wid);
                tbl_hgt[src]  = longint'(c.hgt);
                tbl_hown[src] = c.hown;
                tbl_own[src]  = c.hown ? int'(c.own) : 0;
            end
            OP_ALLOC: begin
                n_alloc++;
                r.status = ST_MISS;
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (!tbl_used[i]) begin
                        tbl_used[i] = 1'b1;
                        r.status    = ST_OK;
                        r.found     = IDX_W'(i);
                        break;
                    end
                end
                if (r.status == ST_MISS) n_full++;
            end
            OP_FREE: begin
                n_free++;
                tbl_used[src] = 1'b0;
                tbl_coll[src] = 1'b0;
                tbl_left[src] = 0;
                tbl_top[src]  = 0;
                tbl_wid[src]  = 0;
                tbl_hgt[src]  = 0;
                tbl_hown[src] = 1'b0;
                tbl_own[src]  = 0;
            end
            default: begin
                n_query++;
                if (!tbl_used[src]) begin
                    r.status = ST_NO_SOURCE;
                    n_nosrc++;
                end else begin
                    r.status = ST_MISS;
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        if (i == src || (tbl_hown[src] && i == tbl_own[src])) continue;
                        if (tbl_used[i] && tbl_coll[i] && boxes_meet(src, i)) begin
                            r.status = ST_OK;
                            r.found  = IDX_W'(i);
                            break;
                        end
                    end
                    if (r.status == ST_OK) n_hit++;
                    else n_miss++;
                end
            end
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        r = int'($urandom_range(0, 99));
        if (calm || r < 45) return 0;
        if (r < 85) return int'($urandom_range(1, 3));
        if (r < 96) return int'($urandom_range(4, 12));
        return int'($urandom_range(20, 60));
    endfunction

    // Every port field but the operation and index is random so that the fields an operation ignores still toggle.
    function automatic slot_cmd_t op_cmd(logic [1:0] op, int idx);
        slot_cmd_t c;
        c.op    = op;
        c.idx   = IDX_W'(idx);
        c.coll  = 1'($urandom);
        c.left  = COORD_BITS'($urandom);
        c.top   = COORD_BITS'($urandom);
        c.wid   = DIM_BITS'($urandom);
        c.hgt   = DIM_BITS'($urandom);
        c.hown  = 1'($urandom);
        c.own   = IDX_W'($urandom);
        c.drain = 1'b0;
        return c;
    endfunction

    function automatic slot_cmd_t box_write(int idx, bit coll, int l, int t, int w, int h,
                                            bit hown, int own);
        slot_cmd_t c;
        c      = op_cmd(OP_WRITE, idx);
        c.coll = coll;
        c.left = COORD_BITS'(l);
        c.top  = COORD_BITS'(t);
        c.wid  = DIM_BITS'(w);
        c.hgt  = DIM_BITS'(h);
        c.hown = hown;
        c.own  = IDX_W'(own);
        return c;
    endfunction

    // Most boxes sit in a small region so that queries find overlaps.
    function automatic slot_cmd_t shape_box(slot_cmd_t c);
        if ($urandom_range(0, 99) < 85) begin
            c.left = COORD_BITS'(int'($urandom_range(0, 400)) - 200);
            c.top  = COORD_BITS'(int'($urandom_range(0, 400)) - 200);
            c.wid  = DIM_BITS'($urandom_range(0, 120));
            c.hgt  = DIM_BITS'($urandom_range(0, 120));
        end
        return c;
    endfunction

    function automatic int pick_slot(int pct_live);
        if (gen_live.size() > 0 && $urandom_range(0, 99) < pct_live)
            return gen_live[$urandom_range(0, gen_live.size() - 1)];
        return int'(IDX_W'($urandom));
    endfunction

    task automatic queue_cmd(slot_cmd_t c);
        int k;
        if (c.op == OP_ALLOC) begin
            for (k = 0; k < SLOT_COUNT; k++) begin
                if (!gen_used[k]) begin
                    gen_used[k] = 1'b1;
                    gen_live.push_back(k);
                    break;
                end
            end
        end else if (c.op == OP_FREE && gen_used[c.idx]) begin
            gen_used[c.idx] = 1'b0;
            for (k = 0; k < gen_live.size(); k++) begin
                if (gen_live[k] == int'(c.idx)) begin
                    gen_live.delete(k);
                    break;
                end
            end
        end
        cmd_backlog.push_back(c);
    endtask

    task automatic note_failure(string msg);
        n_fail++;
        if (n_fail <= 10) $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    always @(posedge aclk) begin
        if (s_valid && s_ready) begin
            reply_queue.push_back(table_apply(cur_cmd));
            s_taken = 1'b1;
        end
    end

    always @(negedge aclk) begin
        if (aresetn && (!s_valid || s_taken)) begin
            s_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left = gap_left - 1;
                s_valid <= 1'b0;
            end else if (cmd_backlog.size() > 0 &&
                         !(cmd_backlog[0].drain && reply_queue.size() > 0)) begin
                cur_cmd = cmd_backlog.pop_front();
                s_valid         <= 1'b1;
                s_operation     <= cur_cmd.op;
                s_slot_index    <= cur_cmd.idx;
                s_is_collidable <= cur_cmd.coll;
                s_box_left      <= cur_cmd.left;
                s_box_top       <= cur_cmd.top;
                s_box_width     <= cur_cmd.wid;
                s_box_height    <= cur_cmd.hgt;
                s_has_owner     <= cur_cmd.hown;
                s_owner_slot    <= cur_cmd.own;
                gap_left = pick_gap();
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
            if (!calm && $urandom_range(0, 99) < 12) stall_left = pick_gap();
        end
    end

    always @(posedge aclk) begin
        scan_reply_t want;
        if (m_valid && m_ready) begin
            if (reply_queue.size() == 0) begin
                note_failure($sformatf("result status=%0d slot=%0d with nothing outstanding",
                                       m_status, m_found_slot));
            end else begin
                want = reply_queue.pop_front();
                if (m_status !== want.status || m_found_slot !== want.found)
                    note_failure($sformatf("status exp %0d got %0d, slot exp %0d got %0d",
                                           want.status, m_status, want.found, m_found_slot));
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 32'd1;
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles = 0;
        else idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d results outstanding",
                     IDLE_LIMIT, reply_queue.size());
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        slot_cmd_t c;
        int        r;

        // Directed: extremes, owner skipping, edge contact, stale contents and repeated free.
        queue_cmd(box_write(5, 1'b1, 0, 0, 10, 10, 1'b0, 0));
        queue_cmd(op_cmd(OP_ALLOC, 0));
        queue_cmd(op_cmd(OP_ALLOC, 0));
        queue_cmd(op_cmd(OP_QUERY, 7));
        queue_cmd(box_write(0, 1'b0, -32768, -32768, 32767, 32767, 1'b0, 0));
        queue_cmd(box_write(1, 1'b1, 32767, 32767, 32767, 32767, 1'b1, 0));
        queue_cmd(op_cmd(OP_QUERY, 1));
        queue_cmd(op_cmd(OP_QUERY, 0));
        queue_cmd(op_cmd(OP_ALLOC, 0));
        queue_cmd(box_write(2, 1'b1, -1, -1, 0, 0, 1'b0, 0));
        queue_cmd(op_cmd(OP_QUERY, 0));
        queue_cmd(op_cmd(OP_ALLOC, 0));
        queue_cmd(op_cmd(OP_ALLOC, 0));
        queue_cmd(op_cmd(OP_ALLOC, 0));
        queue_cmd(box_write(3, 1'b1, 10, 10, 5, 5, 1'b1, 5));
        queue_cmd(op_cmd(OP_QUERY, 3));
        queue_cmd(box_write(4, 1'b1, 15, 15, 0, 0, 1'b1, 1023));
        queue_cmd(op_cmd(OP_QUERY, 3));
        queue_cmd(op_cmd(OP_QUERY, 5));
        queue_cmd(op_cmd(OP_FREE, 2));
        queue_cmd(op_cmd(OP_FREE, 2));
        queue_cmd(op_cmd(OP_QUERY, 2));
        queue_cmd(op_cmd(OP_FREE, 1023));
        queue_cmd(op_cmd(OP_QUERY, 0));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            r = int'($urandom_range(0, 99));
            if ((gen_live.size() < 6 || r < 18) && gen_live.size() < 48) begin
                c = op_cmd(OP_ALLOC, pick_slot(0));
            end else if (r < 48) begin
                c      = shape_box(op_cmd(OP_WRITE, pick_slot(90)));
                c.coll = ($urandom_range(0, 99) < 80);
                c.hown = ($urandom_range(0, 99) < 35);
                c.own  = IDX_W'(pick_slot(70));
            end else if (r < 60) begin
                c = op_cmd(OP_FREE, pick_slot(80));
            end else begin
                c = op_cmd(OP_QUERY, pick_slot(90));
            end
            c.drain = (n % 97 == 50);
            queue_cmd(c);
        end

        // Finish with boxes at the top of the table, queries on live slots, frees and allocations.
        c = op_cmd(OP_ALLOC, 0);
        c.drain = 1'b1;
        queue_cmd(c);
        queue_cmd(box_write(1023, 1'b1, 0, 0, 50, 50, 1'b0, 0));
        queue_cmd(box_write(1000, 1'b1, 40, 40, 0, 0, 1'b1, 1023));
        queue_cmd(op_cmd(OP_QUERY, 1000));
        queue_cmd(op_cmd(OP_QUERY, 1023));
        for (int n = 0; n < 10; n++) queue_cmd(op_cmd(OP_QUERY, pick_slot(100)));
        queue_cmd(op_cmd(OP_FREE, 512));
        queue_cmd(op_cmd(OP_FREE, 3));
        queue_cmd(op_cmd(OP_ALLOC, 0));
        queue_cmd(op_cmd(OP_ALLOC, 0));
        queue_cmd(op_cmd(OP_ALLOC, 0));

        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        while (cmd_backlog.size() != 0 || s_valid || reply_queue.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Covered %0d allocations (%0d on a full table), %0d writes, %0d frees.",
                 n_alloc, n_full, n_write, n_free);
        $display("Covered %0d queries: %0d hits, %0d misses, %0d on unused sources; %0d errors.",
                 n_query, n_hit, n_miss, n_nosrc, n_fail);
        if (n_fail == 0 && reply_queue.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
